// ----- sv/piecewise_linear_colormap_eval_top_defines.svh -----
// Assertion macros for the checker file.
`ifndef PIECEWISE_LINEAR_COLORMAP_EVAL_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_COLORMAP_EVAL_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PLC_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define PLC_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ----- sv/plce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plce_pkg
// Types and constants of the piecewise-linear colormap evaluator.
// ----------------------------------------------------------------------------
package plce_pkg;
  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 15;
  localparam int VAL_W   = 16;
  localparam int ALPHA_W = 19;
  localparam int CFG_W   = 16;
  localparam int CNT_W   = 7;
  localparam int IDX_W   = 6;
  localparam int SCALE_FRAC = 12;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = '1;

  typedef enum logic [1:0] {
    CMD_WR_COLOR   = 2'd0,
    CMD_WR_OPACITY = 2'd1,
    CMD_EVAL       = 2'd2,
    CMD_UNUSED     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_COLOR_CNT   = 2'd0,
    REG_OPACITY_CNT = 2'd1,
    REG_SCALE       = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [IDX_W-1:0] point_index;
    logic [VAL_W-1:0] position;
    logic [VAL_W-1:0] red_in;
    logic [VAL_W-1:0] green_in;
    logic [VAL_W-1:0] blue_in;
    logic [VAL_W-1:0] alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0]   red_out;
    logic [VAL_W-1:0]   green_out;
    logic [VAL_W-1:0]   blue_out;
    logic [ALPHA_W-1:0] alpha_out;
  } out_item_t;
endpackage

// ----- sv/plce_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plce_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module plce_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle; read data appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- sv/plce_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plce_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plce_div #(
  parameter int NW = 34,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [CW-1:0] cnt;
  logic [DW:0]   rem;
  logic [DW:0]   trial;
  logic [DW-1:0] dreg;

  // Shift in the next numerator bit and try a subtraction.
  assign trial = {rem[DW-1:0], quo[NW-1]} - {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
      quo  <= num;
      rem  <= '0;
      dreg <= den;
    end else if (busy) begin
      if (trial[DW]) begin
        rem <= {rem[DW-1:0], quo[NW-1]};
        quo <= {quo[NW-2:0], 1'b0};
      end else begin
        rem <= trial;
        quo <= {quo[NW-2:0], 1'b1};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// ----- sv/piecewise_linear_colormap_eval_top.sv -----
`timescale 1ns / 1ps
// An evaluate, after its input transfer, reads and walks the color table entry
// by entry, then the opacity table the same way, then for each of red, green,
// blue and alpha either copies a point value or interpolates it through the
// 34-step bit-serial divider, then scales alpha and loads the output register.
// Only one evaluate is in flight; the result sits in an output register, and a
// result that still waits only holds the next evaluate at its output step.
// ----------------------------------------------------------------------------
// piecewise_linear_colormap_eval_top
// Piecewise-linear transfer function with color and opacity point tables.
// ----------------------------------------------------------------------------
module piecewise_linear_colormap_eval_top
  #(parameter int MAX_POINTS = plce_pkg::MAX_POINTS_DEF)
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  plce_pkg::in_item_t       in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output plce_pkg::out_item_t      out_data,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [plce_pkg::CFG_W-1:0] cfg_wdata
);
  import plce_pkg::*;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = 2 * VAL_W + 2;
  localparam int DW = VAL_W + 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CREAD = 9'b000000010,
    S_CWALK = 9'b000000100,
    S_OREAD = 9'b000001000,
    S_OWALK = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_DWAIT = 9'b001000000,
    S_SCALE = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic [CNT_W-1:0] color_cnt, opacity_cnt;
  logic [VAL_W-1:0] scale;
  in_item_t cur;
  logic [AW:0] idx;
  logic [CNT_W-1:0] c_eff, o_eff;
  logic [VAL_W-1:0] prv_pos;
  logic [3*VAL_W-1:0] prv_val, c_left, c_right;
  logic [VAL_W-1:0] o_left, o_right;
  logic [VAL_W-1:0] c_n, c_d, o_n, o_d;
  logic c_interp, o_interp, first;
  logic [1:0] lane;
  logic [VAL_W-1:0] res [4];
  logic [63:0] c_rdata;
  logic [31:0] o_rdata;
  logic c_we, o_we;
  logic [AW-1:0] c_addr, o_addr;
  logic div_start, div_busy;
  logic [NW-1:0] num, quo;
  logic [DW-1:0] den;
  logic [VAL_W-1:0] va, vb, vn, vd;
  logic [VAL_W+CFG_W-1:0] prod;
  logic [VAL_W+CFG_W-SCALE_FRAC:0] shifted;
  logic [AW:0] cnt_c_lim, cnt_o_lim;

  // Effective counts: clipped to the table depth, zero acts as one.
  assign cnt_c_lim = (32'(color_cnt) > MAX_POINTS) ? (AW+1)'(MAX_POINTS)
                     : (AW+1)'(color_cnt);
  assign cnt_o_lim = (32'(opacity_cnt) > MAX_POINTS) ? (AW+1)'(MAX_POINTS)
                     : (AW+1)'(opacity_cnt);

  assign in_ready = (state == S_IDLE);

  // Table memories.
  assign c_we = (state == S_IDLE) && in_valid && in_ready
                && in_data.command == CMD_WR_COLOR
                && 32'(in_data.point_index) < MAX_POINTS;
  assign o_we = (state == S_IDLE) && in_valid && in_ready
                && in_data.command == CMD_WR_OPACITY
                && 32'(in_data.point_index) < MAX_POINTS;
  assign c_addr = (state == S_IDLE) ? AW'(in_data.point_index) : idx[AW-1:0];
  assign o_addr = (state == S_IDLE) ? AW'(in_data.point_index) : idx[AW-1:0];

  plce_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_cram (
    .clk(clk), .we(c_we), .addr(c_addr),
    .wdata({in_data.position, in_data.red_in, in_data.green_in, in_data.blue_in}),
    .rdata(c_rdata));
  plce_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_oram (
    .clk(clk), .we(o_we), .addr(o_addr),
    .wdata({in_data.position, in_data.alpha_in}),
    .rdata(o_rdata));

  // Operand selection and divider inputs for the current lane.
  always_comb begin
    unique case (lane)
      2'd0: begin va = c_left[47:32]; vb = c_right[47:32]; end
      2'd1: begin va = c_left[31:16]; vb = c_right[31:16]; end
      2'd2: begin va = c_left[15:0];  vb = c_right[15:0];  end
      default: begin va = o_left; vb = o_right; end
    endcase
    vn = (lane == 2'd3) ? o_n : c_n;
    vd = (lane == 2'd3) ? o_d : c_d;
    num = NW'(va * (vd - vn)) + NW'(vb * vn) + NW'(vd >> 1);
    den = DW'(vd);
  end

  assign div_start = (state == S_DIV)
                     && ((lane == 2'd3) ? o_interp : c_interp);

  plce_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num), .den(den),
    .busy(div_busy), .quo(quo));

  assign prod    = res[3] * scale;
  assign shifted = (VAL_W+CFG_W-SCALE_FRAC+1)'((prod + (1 << (SCALE_FRAC-1))) >> SCALE_FRAC);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_cnt   <= CNT_W'(2);
      opacity_cnt <= CNT_W'(2);
      scale       <= CFG_W'(4096);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_COLOR_CNT:   color_cnt   <= cfg_wdata[CNT_W-1:0];
        REG_OPACITY_CNT: opacity_cnt <= cfg_wdata[CNT_W-1:0];
        REG_SCALE:       scale       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: walk each table, then copy or divide lane by lane.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cur <= in_data;
            if (in_data.command == CMD_EVAL) begin
              idx   <= '0;
              c_eff <= CNT_W'(cnt_c_lim == '0 ? (AW+1)'(1) : cnt_c_lim);
              o_eff <= CNT_W'(cnt_o_lim == '0 ? (AW+1)'(1) : cnt_o_lim);
              state <= S_CREAD;
            end
          end
        end
        S_CREAD: begin
          first <= 1'b1;
          idx   <= idx + 1'b1;
          state <= S_CWALK;
        end
        S_CWALK: begin
          first   <= 1'b0;
          prv_pos <= c_rdata[63:48];
          prv_val <= c_rdata[47:0];
          if (first && cur.position <= c_rdata[63:48]) begin
            c_left <= c_rdata[47:0]; c_right <= c_rdata[47:0];
            c_interp <= 1'b0; idx <= '0; state <= S_OREAD;
          end else if (!first && cur.position <= c_rdata[63:48]) begin
            c_left <= prv_val; c_right <= c_rdata[47:0];
            c_n <= cur.position - prv_pos; c_d <= c_rdata[63:48] - prv_pos;
            c_interp <= 1'b1; idx <= '0; state <= S_OREAD;
          end else if (CNT_W'(idx) >= c_eff) begin
            c_left <= c_rdata[47:0]; c_right <= c_rdata[47:0];
            c_interp <= 1'b0; idx <= '0; state <= S_OREAD;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_OREAD: begin
          first <= 1'b1;
          idx   <= idx + 1'b1;
          state <= S_OWALK;
        end
        S_OWALK: begin
          first   <= 1'b0;
          prv_pos <= o_rdata[31:16];
          prv_val <= {32'd0, o_rdata[15:0]};
          lane    <= 2'd0;
          if (first && cur.position <= o_rdata[31:16]) begin
            o_left <= o_rdata[15:0]; o_right <= o_rdata[15:0];
            o_interp <= 1'b0; state <= S_DIV;
          end else if (!first && cur.position <= o_rdata[31:16]) begin
            o_left <= prv_val[15:0]; o_right <= o_rdata[15:0];
            o_n <= cur.position - prv_pos; o_d <= o_rdata[31:16] - prv_pos;
            o_interp <= 1'b1; state <= S_DIV;
          end else if (CNT_W'(idx) >= o_eff) begin
            o_left <= o_rdata[15:0]; o_right <= o_rdata[15:0];
            o_interp <= 1'b0; state <= S_DIV;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DIV: begin
          if (div_start) begin
            state <= S_DWAIT;
          end else begin
            res[lane] <= va;
            if (lane == 2'd3) state <= S_SCALE;
            else lane <= lane + 1'b1;
          end
        end
        S_DWAIT: begin
          if (!div_busy) begin
            res[lane] <= quo[VAL_W-1:0];
            state <= (lane == 2'd3) ? S_SCALE : S_DIV;
            lane  <= lane + 1'b1;
          end
        end
        S_SCALE: begin
          // The alpha product settles from the registered lane results.
          state <= S_OUT;
        end
        S_OUT: begin
          // Load the output register only once the previous result has left.
          if (!out_valid) begin
            out_data.red_out   <= res[0];
            out_data.green_out <= res[1];
            out_data.blue_out  <= res[2];
            out_data.alpha_out <= (shifted > (VAL_W+CFG_W-SCALE_FRAC+1)'(ALPHA_MAX))
                                  ? ALPHA_MAX : ALPHA_W'(shifted);
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- sv/plce_checker.sv -----
`timescale 1ns / 1ps
`include "piecewise_linear_colormap_eval_top_defines.svh"
// ----------------------------------------------------------------------------
// plce_checker
// Port-level checks of the colormap evaluator.
// ----------------------------------------------------------------------------
module plce_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input plce_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input plce_pkg::out_item_t out_data
);
  import plce_pkg::*;
  // Output holds while stalled.
  `PLC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "output changed while stalled")
  // A waiting input item stays offered and unchanged.
  `PLC_ASSERT_NXT(a_in_hold, clk, rst, in_valid && !in_ready, in_valid && $stable(in_data), "input changed while waiting")
  // A write or an unused command never produces a result next cycle.
  `PLC_ASSERT_NXT(a_wr_quiet, clk, rst, in_valid && in_ready && in_data.command != CMD_EVAL, !$rose(out_valid), "result after write")
endmodule

bind piecewise_linear_colormap_eval_top plce_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the piecewise-linear colormap evaluator. Loads
// color and opacity point tables, evaluates positions under several count
// and scale settings, and compares every result with an in-bench predictor.
// ----------------------------------------------------------------------------
module tb;
  import plce_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  reg_idx_t cfg_index = REG_COLOR_CNT;
  logic [CFG_W-1:0] cfg_wdata = '0;

  piecewise_linear_colormap_eval_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: shadow tables and registers.
  logic [VAL_W-1:0] cpos_tab [64];
  logic [VAL_W-1:0] cval_tab [64][3];
  logic [VAL_W-1:0] opos_tab [64];
  logic [VAL_W-1:0] oval_tab [64];
  int unsigned n_color = 2;
  int unsigned n_opacity = 2;
  int unsigned alpha_scale = 4096;

  out_item_t expected_colors[$];
  int errors = 0;
  int evals_done = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic int unsigned clip_count(int unsigned c);
    if (c > 64) c = 64;
    if (c == 0) c = 1;
    return c;
  endfunction

  function automatic int unsigned lerp_q15(int unsigned a, int unsigned b,
                                           int unsigned n, int unsigned d);
    longint unsigned acc;
    acc = longint'(a) * (d - n) + longint'(b) * n + d / 2;
    return int'(acc / d);
  endfunction

  // Segment search: 0 is at/below the first point, cnt is past the last.
  function automatic int unsigned find_segment(bit use_color, int unsigned cnt,
                                               int unsigned x);
    int unsigned i;
    int unsigned p0;
    p0 = use_color ? cpos_tab[0] : opos_tab[0];
    if (x <= p0) return 0;
    for (i = 1; i < cnt; i++)
      if (x <= (use_color ? cpos_tab[i] : opos_tab[i])) return i;
    return cnt;
  endfunction

  function automatic out_item_t colormap_at(int unsigned x);
    out_item_t r;
    int unsigned cn, on, s, k, v, a;
    longint unsigned prod;
    logic [VAL_W-1:0] chan [3];
    cn = clip_count(n_color);
    on = clip_count(n_opacity);
    s = find_segment(1'b1, cn, x);
    for (k = 0; k < 3; k++) begin
      if (s == 0) v = cval_tab[0][k];
      else if (s >= cn) v = cval_tab[cn-1][k];
      else v = lerp_q15(cval_tab[s-1][k], cval_tab[s][k], x - cpos_tab[s-1],
                        cpos_tab[s] - cpos_tab[s-1]);
      chan[k] = v[VAL_W-1:0];
    end
    s = find_segment(1'b0, on, x);
    if (s == 0) a = oval_tab[0];
    else if (s >= on) a = oval_tab[on-1];
    else a = lerp_q15(oval_tab[s-1], oval_tab[s], x - opos_tab[s-1],
                      opos_tab[s] - opos_tab[s-1]);
    prod = (longint'(a) * alpha_scale + 2048) >> SCALE_FRAC;
    if (prod > 524287) prod = 524287;
    r.red_out = chan[0];
    r.green_out = chan[1];
    r.blue_out = chan[2];
    r.alpha_out = prod[ALPHA_W-1:0];
    return r;
  endfunction

  // Send one item; the predictor runs when the transfer happens. Valid stays
  // high after the transfer until the next item or an explicit drain.
  task automatic send_item(in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    case (cmd_t'(it.command))
      CMD_WR_COLOR: begin
        cpos_tab[it.point_index] = it.position;
        cval_tab[it.point_index][0] = it.red_in;
        cval_tab[it.point_index][1] = it.green_in;
        cval_tab[it.point_index][2] = it.blue_in;
      end
      CMD_WR_OPACITY: begin
        opos_tab[it.point_index] = it.position;
        oval_tab[it.point_index] = it.alpha_in;
      end
      CMD_EVAL: expected_colors = {expected_colors, colormap_at(it.position)};
      default: ;
    endcase
  endtask

  // Stop offering input and wait until every expected result has come.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
  endtask

  function automatic in_item_t make_item(cmd_t c, int unsigned idx, int unsigned p,
                                         int unsigned r, int unsigned g,
                                         int unsigned b, int unsigned a);
    in_item_t it;
    it.command = c;
    it.point_index = idx[IDX_W-1:0];
    it.position = p[VAL_W-1:0];
    it.red_in = r[VAL_W-1:0];
    it.green_in = g[VAL_W-1:0];
    it.blue_in = b[VAL_W-1:0];
    it.alpha_in = a[VAL_W-1:0];
    return it;
  endfunction

  // Random 16-bit field value; mostly in range, sometimes any bit pattern.
  function automatic int unsigned rand_q15();
    if ($urandom_range(9, 0) == 0) return $urandom_range(65535, 0);
    return $urandom_range(32768, 0);
  endfunction

  task automatic send_eval(int unsigned x);
    send_item(make_item(CMD_EVAL, $urandom_range(63, 0), x, $urandom_range(65535, 0),
                        $urandom_range(65535, 0), $urandom_range(65535, 0),
                        $urandom_range(65535, 0)));
  endtask

  // Drain, let trailing writes finish, then write one register.
  task automatic write_register(reg_idx_t idx, int unsigned val);
    drain();
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COLOR_CNT: n_color = val & 7'h7f;
      REG_OPACITY_CNT: n_opacity = val & 7'h7f;
      default: alpha_scale = val & 16'hffff;
    endcase
  endtask

  // Fill the first cnt entries of both tables, with sorted positions when ordered is set.
  task automatic load_tables(int unsigned cnt, bit ordered);
    int unsigned k, p, q;
    p = 0;
    q = 0;
    for (k = 0; k < cnt; k++) begin
      if (ordered) begin
        p = (k == 0) ? $urandom_range(2000, 0) : p + $urandom_range(32768 / cnt, 0);
        q = (k == 0) ? $urandom_range(2000, 0) : q + $urandom_range(32768 / cnt, 0);
        if (p > 32768) p = 32768;
        if (q > 32768) q = 32768;
      end else begin
        p = rand_q15();
        q = rand_q15();
      end
      send_item(make_item(CMD_WR_COLOR, k, p, rand_q15(), rand_q15(), rand_q15(),
                          $urandom_range(65535, 0)));
      send_item(make_item(CMD_WR_OPACITY, k, q, $urandom_range(65535, 0),
                          $urandom_range(65535, 0), $urandom_range(65535, 0),
                          rand_q15()));
    end
  endtask

  // Directed corners: field extremes, every command, boundary positions.
  task automatic test_directed();
    send_item(make_item(CMD_WR_COLOR, 0, 0, 0, 32768, 65535, 0));
    send_item(make_item(CMD_WR_COLOR, 1, 32768, 32768, 0, 0, 65535));
    send_item(make_item(CMD_WR_OPACITY, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_WR_OPACITY, 1, 32768, 0, 0, 0, 32768));
    send_eval(0);
    send_eval(1);
    send_eval(16384);
    send_eval(32767);
    send_eval(32768);
    send_eval(65535);
    send_item(make_item(CMD_UNUSED, 63, 65535, 65535, 65535, 65535, 65535));
    // Duplicate positions form a step.
    send_item(make_item(CMD_WR_COLOR, 1, 0, 65535, 65535, 65535, 0));
    send_item(make_item(CMD_WR_OPACITY, 1, 0, 0, 0, 0, 65535));
    send_eval(0);
    send_eval(100);
    write_register(REG_SCALE, 40960);
    send_eval(100);
    write_register(REG_SCALE, 65535);
    send_eval(100);
    write_register(REG_SCALE, 0);
    send_eval(7);
  endtask

  // Random phase at one table size and scale; tables are reloaded on request.
  task automatic test_random_phase(int unsigned cnt_c, int unsigned cnt_o,
                                   int unsigned scale, int unsigned n_items,
                                   bit reload);
    int unsigned k, mx;
    mx = (cnt_c > cnt_o) ? cnt_c : cnt_o;
    if (mx > 64) mx = 64;
    if (mx < 2) mx = 2;
    write_register(REG_COLOR_CNT, cnt_c);
    write_register(REG_OPACITY_CNT, cnt_o);
    write_register(REG_SCALE, scale);
    if (reload) load_tables(mx, $urandom_range(3, 0) != 0);
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(9, 0) == 0)
        send_item(make_item(cmd_t'($urandom_range(1, 0)), $urandom_range(mx - 1, 0),
                            rand_q15(), rand_q15(), rand_q15(), rand_q15(), rand_q15()));
      else if ($urandom_range(49, 0) == 0)
        send_item(make_item(CMD_UNUSED, $urandom_range(63, 0), rand_q15(), 0, 0, 0, 0));
      else
        send_eval(rand_q15());
    end
  endtask

  task automatic test_sweep(bit reload);
    test_random_phase(2, 2, 4096, 60, reload);
    test_random_phase(64, 64, 40960, 40, reload);
    test_random_phase(0, 127, 0, 30, reload);
    test_random_phase($urandom_range(64, 2), $urandom_range(64, 2),
                      $urandom_range(40960, 0), 70, reload);
    // Hold off until the block has answered everything outstanding.
    drain();
    test_random_phase(8, 3, 65535, 60, reload);
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (!rst) begin
      if (recv_idle_pct > 0) out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      else out_ready <= 1'b1;
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          out_item_t e;
          e = expected_colors.pop_front();
          evals_done++;
          if (out_data.red_out !== e.red_out) begin
            $error("red_out: expected %0d, got %0d", e.red_out, out_data.red_out);
            errors++;
          end
          if (out_data.green_out !== e.green_out) begin
            $error("green_out: expected %0d, got %0d", e.green_out, out_data.green_out);
            errors++;
          end
          if (out_data.blue_out !== e.blue_out) begin
            $error("blue_out: expected %0d, got %0d", e.blue_out, out_data.blue_out);
            errors++;
          end
          if (out_data.alpha_out !== e.alpha_out) begin
            $error("alpha_out: expected %0d, got %0d", e.alpha_out, out_data.alpha_out);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle_pct = 22;
    recv_idle_pct = 84;
    test_sweep(1'b1);
    send_idle_pct = 84;
    recv_idle_pct = 22;
    test_sweep(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_sweep(1'b0);
    drain();
    repeat (500) @(posedge clk);
    if (expected_colors.size() != 0) errors++;
    $display("tb: %0d evaluations checked over table sizes 1..64 and scales 0..max",
             evals_done);
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  // Watchdog sized for worst-case latency under heavy stalls.
  initial begin
    #200ms;
    $display("tb: FAIL");
    $finish;
  end
endmodule
